[rtl/core/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, widths and codes for the polyline dash splitter.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int COORD_BITS       = 20;
  localparam int LEN_W            = COORD_BITS + 1;
  localparam int PROD_W           = 2 * COORD_BITS + 2;
  localparam int TOTAL_W          = 20;
  localparam int DIVR_W           = (LEN_W > TOTAL_W) ? LEN_W : TOTAL_W;
  localparam int NUM_SLOTS        = 8;
  localparam int DEF_MAX_DASHES   = 8;
  localparam int DEF_MAX_PIECES   = 32;

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic OUT_MOVE = 1'b0;
  localparam logic OUT_LINE = 1'b1;

  localparam logic [1:0] REG_DASH_COUNT = 2'd0;
  localparam logic [1:0] REG_LENS_LOW   = 2'd1;
  localparam logic [1:0] REG_LENS_HIGH  = 2'd2;
  localparam logic [1:0] REG_OFFSET     = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [1:0]                   point_kind;
    logic                         path_start;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_kind;
    logic                         last_of_run;
    logic                         truncated;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  kind;
  } ram_word_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] q;
    logic [DIVR_W-1:0] r;
  } alu_rsp_t;

  typedef struct packed {
    logic [3:0]                 n;
    logic [NUM_SLOTS-1:0][15:0] lens;
    logic [TOTAL_W-1:0]         total;
    logic [19:0]                offset;
  } cfg_view_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PH_DIV,
    S_PH_WAIT,
    S_PH_WALK,
    S_DISPATCH,
    S_SQ_X,
    S_SQ_XW,
    S_SQ_Y,
    S_SQ_YW,
    S_SQRT,
    S_SQRT_W,
    S_INIT,
    S_INIT2,
    S_LOOP,
    S_AX_MUL,
    S_AX_MW,
    S_AX_DIV,
    S_AX_DW,
    S_AY_MUL,
    S_AY_MW,
    S_AY_DIV,
    S_AY_DW,
    S_EMIT_A,
    S_EMIT_B,
    S_END,
    S_FIN,
    S_RD_ISSUE,
    S_RD_WAIT
  } state_t;

endpackage

[rtl/core/polyline_dash_splitter_top.sv]
// ----------------------------------------------------------------------------
// polyline_dash_splitter_top
// Cuts line segments of a point stream into dash pieces from a cyclic table.
//
//   channel  handshake            payload
//   point    point_valid/stall    point_t  (x, y, kind, path_start)
//   result   result_valid/stall   result_t (x, y, kind, last, truncated)
//   cfg      cfg_valid/ready      cfg_index, cfg_data
//
// One point is worked at a time; point_stall is low only between items.
// A segment's length takes two squares and a square root in the shared bit-serial unit,
// then each piece takes two multiplies and two divides,
// then each result is read back from the piece buffer, waiting while stalled.
// A path start adds a divide for the offset modulo plus a walk over the table entries.
// Reset is synchronous; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
module polyline_dash_splitter_top import pds_pkg::*; #(
  parameter int MAX_DASHES = DEF_MAX_DASHES,
  parameter int MAX_PIECES = DEF_MAX_PIECES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        point_valid,
  output logic        point_stall,
  input  point_t      point,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int DEPTH = 2 * MAX_PIECES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PC_W  = $clog2(MAX_PIECES + 1);
  localparam int WC_W  = $clog2(DEPTH + 1);

  state_t state, state_next;
  cfg_view_t cfgv;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  point_t              cur;
  logic [C-1:0]        prev_x, prev_y;
  logic                subpath_open, pen_down;
  logic [2:0]          dash_index;
  logic [15:0]         dash_consumed;

  logic signed [C:0]   dx, dy;
  logic [C-1:0]        adx, ady;
  logic [PROD_W-1:0]   sumsq;
  logic [LEN_W-1:0]    seg_len, pos;
  logic [15:0]         step_len;
  logic signed [16:0]  rem_dash;
  logic [2:0]          idx;
  logic [C-1:0]        cx, cy, ex, ey;
  logic [PC_W-1:0]     pieces;
  logic                trunc;
  logic [WC_W-1:0]     wcnt;
  logic [AW-1:0]       rd_ptr;
  logic [TOTAL_W-1:0]  phase_r, walk_acc;
  logic [3:0]          walk_i;

  logic                ram_we;
  ram_word_t           ram_wdata, ram_rdata;
  logic                out_free, load_result, rd_last;
  logic [LEN_W-1:0]    left, rem_ext, step;
  logic [19:0]         aoff;
  logic [C-1:0]        part;
  logic [16:0]         rem_after;
  logic [TOTAL_W:0]    walk_sum;

  function automatic logic [2:0] next_idx(input logic [2:0] i, input logic [3:0] n);
    if ({1'b0, i} + 4'd1 == n) begin
      return 3'd0;
    end
    return i + 3'd1;
  endfunction

  pds_cfg #(.MAX_DASHES(MAX_DASHES)) u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .view(cfgv)
  );

  pds_alu u_alu (.clk, .rst, .req(alu_req), .rsp(alu_rsp));

  pds_ram #(.WIDTH($bits(ram_word_t)), .DEPTH(DEPTH)) u_buf (
    .clk, .we(ram_we), .waddr(wcnt[AW-1:0]), .wdata(ram_wdata),
    .raddr(rd_ptr), .rdata(ram_rdata)
  );

  always_comb begin
    aoff      = cfgv.offset[19] ? (~cfgv.offset + 20'd1) : cfgv.offset;
    left      = seg_len - pos;
    rem_ext   = LEN_W'(rem_dash[15:0]);
    step      = (rem_ext < left) ? rem_ext : left;
    part      = alu_rsp.q[C-1:0];
    rem_after = rem_dash - 17'(step_len);
    walk_sum  = (TOTAL_W + 1)'(walk_acc) + (TOTAL_W + 1)'(cfgv.lens[walk_i[2:0]]);
    out_free  = !result_valid || !result_stall;
    rd_last   = (WC_W'(rd_ptr) == wcnt - WC_W'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (point_valid) state_next = point.path_start ? S_PH_DIV : S_DISPATCH;
      S_PH_DIV:   state_next = (cfgv.total == '0) ? S_DISPATCH : S_PH_WAIT;
      S_PH_WAIT:  if (alu_rsp.done) state_next = S_PH_WALK;
      S_PH_WALK: begin
        if (walk_i == cfgv.n || TOTAL_W'(phase_r) < walk_sum) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (cur.point_kind == KIND_MOVE || cur.point_kind == KIND_NONE || !subpath_open) begin
          state_next = S_IDLE;
        end else if (cfgv.total == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SQ_X;
        end
      end
      S_SQ_X:     state_next = S_SQ_XW;
      S_SQ_XW:    if (alu_rsp.done) state_next = S_SQ_Y;
      S_SQ_Y:     state_next = S_SQ_YW;
      S_SQ_YW:    if (alu_rsp.done) state_next = S_SQRT;
      S_SQRT:     state_next = S_SQRT_W;
      S_SQRT_W:   if (alu_rsp.done) state_next = S_INIT;
      S_INIT:     state_next = (seg_len == '0) ? S_FIN : S_INIT2;
      S_INIT2:    state_next = S_LOOP;
      S_LOOP: begin
        if (pos == seg_len || pieces == PC_W'(MAX_PIECES)) begin
          state_next = S_END;
        end else begin
          state_next = S_AX_MUL;
        end
      end
      S_AX_MUL:   state_next = S_AX_MW;
      S_AX_MW:    if (alu_rsp.done) state_next = S_AX_DIV;
      S_AX_DIV:   state_next = S_AX_DW;
      S_AX_DW:    if (alu_rsp.done) state_next = S_AY_MUL;
      S_AY_MUL:   state_next = S_AY_MW;
      S_AY_MW:    if (alu_rsp.done) state_next = S_AY_DIV;
      S_AY_DIV:   state_next = S_AY_DW;
      S_AY_DW:    if (alu_rsp.done) state_next = S_EMIT_A;
      S_EMIT_A:   state_next = S_EMIT_B;
      S_EMIT_B:   state_next = S_LOOP;
      S_END:      state_next = S_FIN;
      S_FIN:      state_next = (wcnt != '0) ? S_RD_ISSUE : S_IDLE;
      S_RD_ISSUE: state_next = S_RD_WAIT;
      S_RD_WAIT:  if (out_free) state_next = rd_last ? S_IDLE : S_RD_ISSUE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    point_stall = (state != S_IDLE);
    alu_req     = '0;
    alu_req.op  = OP_MUL;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    load_result = 1'b0;
    unique case (state)
      S_PH_DIV: begin
        alu_req.start = (cfgv.total != '0);
        alu_req.op    = OP_DIV;
        alu_req.a     = PROD_W'(aoff);
        alu_req.b     = PROD_W'(cfgv.total);
      end
      S_SQ_X: begin
        alu_req.start = 1'b1;
        alu_req.a     = PROD_W'(dx[C] ? C'(-dx) : dx[C-1:0]);
        alu_req.b     = PROD_W'(dx[C] ? C'(-dx) : dx[C-1:0]);
      end
      S_SQ_Y: begin
        alu_req.start = 1'b1;
        alu_req.a     = PROD_W'(ady);
        alu_req.b     = PROD_W'(ady);
      end
      S_SQRT: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_req.a     = sumsq;
      end
      S_AX_MUL: begin
        alu_req.start = 1'b1;
        alu_req.a     = PROD_W'(adx);
        alu_req.b     = PROD_W'(pos);
      end
      S_AY_MUL: begin
        alu_req.start = 1'b1;
        alu_req.a     = PROD_W'(ady);
        alu_req.b     = PROD_W'(pos);
      end
      S_AX_DIV, S_AY_DIV: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.a     = alu_rsp.q + PROD_W'(seg_len >> 1);
        alu_req.b     = PROD_W'(seg_len);
      end
      S_EMIT_A: begin
        ram_we    = (idx[0] == 1'b0) ? !pen_down : pen_down;
        ram_wdata = '{x: cx, y: cy, kind: OUT_MOVE};
      end
      S_EMIT_B: begin
        ram_we    = (idx[0] == 1'b0);
        ram_wdata = '{x: ex, y: ey, kind: OUT_LINE};
      end
      S_RD_WAIT:  load_result = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_x        <= '0;
      prev_y        <= '0;
      subpath_open  <= 1'b0;
      pen_down      <= 1'b0;
      dash_index    <= '0;
      dash_consumed <= '0;
      result_valid  <= 1'b0;
      wcnt          <= '0;
      pieces        <= '0;
    end else begin
      state <= state_next;
      if (result_valid && !result_stall && !load_result) begin
        result_valid <= 1'b0;
      end
      if (ram_we) begin
        wcnt <= wcnt + WC_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (point_valid) begin
            cur <= point;
            if (point.path_start) begin
              pen_down     <= 1'b0;
              subpath_open <= 1'b0;
            end
          end
        end
        S_PH_DIV: begin
          dash_index    <= '0;
          dash_consumed <= '0;
        end
        S_PH_WAIT: begin
          if (cfgv.offset[19] && alu_rsp.r[TOTAL_W-1:0] != '0) begin
            phase_r <= cfgv.total - alu_rsp.r[TOTAL_W-1:0];
          end else begin
            phase_r <= alu_rsp.r[TOTAL_W-1:0];
          end
          walk_acc <= '0;
          walk_i   <= '0;
        end
        S_PH_WALK: begin
          if (walk_i != cfgv.n) begin
            if ((TOTAL_W + 1)'(phase_r) < walk_sum) begin
              dash_index    <= walk_i[2:0];
              dash_consumed <= 16'(phase_r - walk_acc);
            end else begin
              walk_acc <= walk_sum[TOTAL_W-1:0];
              walk_i   <= walk_i + 4'd1;
            end
          end
        end
        S_DISPATCH: begin
          wcnt <= '0;
          dx   <= {cur.point_x[C-1], cur.point_x} - {prev_x[C-1], prev_x};
          dy   <= {cur.point_y[C-1], cur.point_y} - {prev_y[C-1], prev_y};
          if (cur.point_kind == KIND_MOVE) begin
            prev_x       <= cur.point_x;
            prev_y       <= cur.point_y;
            subpath_open <= 1'b1;
            pen_down     <= 1'b0;
          end
        end
        S_SQ_X: begin
          adx <= dx[C] ? C'(-dx) : dx[C-1:0];
          ady <= dy[C] ? C'(-dy) : dy[C-1:0];
        end
        S_SQ_XW:  if (alu_rsp.done) sumsq <= alu_rsp.q;
        S_SQ_YW:  if (alu_rsp.done) sumsq <= sumsq + alu_rsp.q;
        S_SQRT_W: if (alu_rsp.done) seg_len <= alu_rsp.q[LEN_W-1:0];
        S_INIT: begin
          cx     <= prev_x;
          cy     <= prev_y;
          pos    <= '0;
          pieces <= '0;
          trunc  <= 1'b0;
          if ({1'b0, dash_index} >= cfgv.n) begin
            idx      <= '0;
            rem_dash <= 17'(cfgv.lens[0]);
          end else begin
            idx      <= dash_index;
            rem_dash <= 17'(cfgv.lens[dash_index]) - 17'(dash_consumed);
          end
        end
        S_INIT2: begin
          if (rem_dash <= 17'sd0) begin
            idx      <= next_idx(idx, cfgv.n);
            rem_dash <= 17'(cfgv.lens[next_idx(idx, cfgv.n)]);
          end
        end
        S_LOOP: begin
          if (pos != seg_len) begin
            if (pieces == PC_W'(MAX_PIECES)) begin
              trunc <= 1'b1;
            end else begin
              step_len <= step[15:0];
              pos      <= pos + step;
              pieces   <= pieces + PC_W'(1);
            end
          end
        end
        S_AX_DW: if (alu_rsp.done) ex <= dx[C] ? prev_x - part : prev_x + part;
        S_AY_DW: if (alu_rsp.done) ey <= dy[C] ? prev_y - part : prev_y + part;
        S_EMIT_A: if (idx[0]) pen_down <= 1'b0;
        S_EMIT_B: begin
          if (!idx[0]) begin
            pen_down <= 1'b1;
          end
          cx <= ex;
          cy <= ey;
          if (rem_after == 17'd0 && pos != seg_len) begin
            idx      <= next_idx(idx, cfgv.n);
            rem_dash <= 17'(cfgv.lens[next_idx(idx, cfgv.n)]);
          end else begin
            rem_dash <= rem_after;
          end
        end
        S_END: begin
          if (trunc) begin
            pen_down <= 1'b0;
          end
          dash_index    <= idx;
          dash_consumed <= cfgv.lens[idx] - rem_dash[15:0];
        end
        S_FIN: begin
          prev_x <= cur.point_x;
          prev_y <= cur.point_y;
          rd_ptr <= '0;
          if (cur.point_kind == KIND_CLOSE) begin
            subpath_open <= 1'b0;
            pen_down     <= 1'b0;
          end
          if (cfgv.total == '0 || seg_len == '0) begin
            trunc <= 1'b0;
          end
        end
        S_RD_WAIT: begin
          if (load_result) begin
            result_valid       <= 1'b1;
            result.out_x       <= ram_rdata.x;
            result.out_y       <= ram_rdata.y;
            result.out_kind    <= ram_rdata.kind;
            result.last_of_run <= rd_last;
            result.truncated   <= trunc;
            rd_ptr             <= rd_ptr + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_rise_in_replay: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_RD_WAIT)
    else $error("result raised outside replay");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    wcnt <= WC_W'(DEPTH))
    else $error("piece buffer overflow");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> pos <= seg_len)
    else $error("position past segment end");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> point_stall)
    else $error("point taken while busy");

endmodule

[rtl/core/pds_ram.sv]
// ----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pds_cfg.sv]
// ----------------------------------------------------------------------------
// pds_cfg
// Configuration registers; clamped entry count and registered pattern total.
// ----------------------------------------------------------------------------
module pds_cfg import pds_pkg::*; #(
  parameter int MAX_DASHES = DEF_MAX_DASHES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_view_t   view
);

  logic [3:0]  dash_count;
  logic [63:0] lens_low;
  logic [63:0] lens_high;
  logic [19:0] dash_offset;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [3:0]  n_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_count  <= 4'd2;
      lens_low    <= 64'h0000_0000_0040_0040;
      lens_high   <= 64'd0;
      dash_offset <= 20'd0;
      total       <= TOTAL_W'(128);
    end else begin
      total <= total_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DASH_COUNT: dash_count  <= cfg_data[3:0];
          REG_LENS_LOW:   lens_low    <= cfg_data;
          REG_LENS_HIGH:  lens_high   <= cfg_data;
          REG_OFFSET:     dash_offset <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (dash_count == 4'd0) begin
      n_use = 4'd1;
    end else if (dash_count > 4'(MAX_DASHES)) begin
      n_use = 4'(MAX_DASHES);
    end else begin
      n_use = dash_count;
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (4'(i) < n_use) begin
        total_next = total_next + TOTAL_W'(view.lens[i]);
      end
    end
  end

  always_comb begin
    view.n      = n_use;
    view.lens   = {lens_high, lens_low};
    view.total  = total;
    view.offset = dash_offset;
  end

endmodule

[rtl/core/pds_alu.sv]
// ----------------------------------------------------------------------------
// pds_alu
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module pds_alu import pds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int CNT_W = $clog2(PROD_W + 1);
  localparam int SR_W  = LEN_W + 2;

  logic              busy;
  logic              done;
  alu_op_t           op;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] opa;
  logic [PROD_W-1:0] opb;
  logic [PROD_W-1:0] acc;
  logic [DIVR_W-1:0] drem;
  logic [SR_W-1:0]   srem;

  logic [DIVR_W:0]   dt;
  logic              dge;
  logic [SR_W+1:0]   st;
  logic [SR_W+1:0]   trial;
  logic              sge;
  logic [DIVR_W:0]   dsub;
  logic [SR_W+1:0]   ssub;

  always_comb begin
    dt    = {drem, opa[PROD_W-1]};
    dge   = dt >= {1'b0, opb[DIVR_W-1:0]};
    dsub  = dt - {1'b0, opb[DIVR_W-1:0]};
    st    = {srem, opa[PROD_W-1 -: 2]};
    trial = (SR_W + 2)'({acc[LEN_W-1:0], 2'b01});
    sge   = st >= trial;
    ssub  = st - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        opa  <= req.a;
        opb  <= req.b;
        acc  <= '0;
        drem <= '0;
        srem <= '0;
        unique case (req.op)
          OP_MUL:  cnt <= CNT_W'(LEN_W);
          OP_DIV:  cnt <= CNT_W'(PROD_W);
          OP_SQRT: cnt <= CNT_W'(PROD_W / 2);
          default: cnt <= CNT_W'(1);
        endcase
      end else if (busy) begin
        unique case (op)
          OP_MUL: begin
            if (opb[0]) begin
              acc <= acc + opa;
            end
            opa <= opa << 1;
            opb <= opb >> 1;
          end
          OP_DIV: begin
            acc  <= {acc[PROD_W-2:0], dge};
            drem <= dge ? dsub[DIVR_W-1:0] : dt[DIVR_W-1:0];
            opa  <= opa << 1;
          end
          OP_SQRT: begin
            acc  <= {acc[PROD_W-2:0], sge};
            srem <= sge ? ssub[SR_W-1:0] : st[SR_W-1:0];
            opa  <= opa << 2;
          end
          default: ;
        endcase
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = acc;
  assign rsp.r    = drem;

endmodule
